[hdl/kmsd_pkg.sv]
// Package for the key matrix scan and debounce core.
// Holds fixed widths, register indexes and the lane result type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kmsd_pkg;

  localparam int unsigned KeySlots     = 16;
  localparam int unsigned KeyW         = 4;
  localparam int unsigned RowInputBits = 4;
  localparam int unsigned TickW        = 32;
  localparam int unsigned MaskW        = 16;
  localparam int unsigned DriveW       = 2;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 32;

  localparam logic [CfgIdxW-1:0] RegScanInterval = 1'd0;
  localparam logic [CfgIdxW-1:0] RegUsedKeyMask  = 1'd1;

  localparam logic [TickW-1:0] ScanIntervalReset = 32'd1000;
  localparam logic [MaskW-1:0] UsedKeyMaskReset  = 16'hFFFF;

  typedef struct packed {
    logic            rise;
    logic            fall;
    logic [KeyW-1:0] key;
  } lane_res_t;

endpackage
`default_nettype wire

[hdl/kmsd_lane.sv]
// One row lane: keeps the debounce histories of its row for every column.
// Depends on kmsd_pkg for widths and the lane result type.
`timescale 1ns / 1ps
`default_nettype none
module kmsd_lane #(
  parameter int unsigned ROWS         = 4,
  parameter int unsigned COLUMNS      = 4,
  parameter int unsigned HISTORY_BITS = 8,
  parameter int unsigned LANE         = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          scan_i,
  input  wire logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] col_i,
  input  wire logic                          sample_i,
  input  wire logic [kmsd_pkg::MaskW-1:0]    used_mask_i,
  input  wire logic [kmsd_pkg::KeySlots-1:0] bitmap_i,
  output kmsd_pkg::lane_res_t                res_o
);

  localparam int unsigned ColW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned KiW  = ColW + 4;

  logic [COLUMNS-1:0][HISTORY_BITS-1:0] hist_q;
  logic [HISTORY_BITS-1:0]              hist_d;
  logic [KiW-1:0]                       key_wide;
  logic [kmsd_pkg::KeyW-1:0]            key;
  logic                                 key_ok;
  logic                                 upd;
  logic                                 was;

  assign key_wide = KiW'(col_i) * KiW'(ROWS) + KiW'(LANE);
  assign key_ok   = key_wide < KiW'(kmsd_pkg::KeySlots);
  assign key      = key_wide[kmsd_pkg::KeyW-1:0];
  assign upd      = scan_i && key_ok && used_mask_i[key];
  assign was      = bitmap_i[key];
  assign hist_d   = {hist_q[col_i][HISTORY_BITS-2:0], sample_i};

  always_comb begin
    res_o.key  = key;
    res_o.rise = upd && !was && (&hist_d);
    res_o.fall = upd && was && (hist_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (upd) begin
      hist_q[col_i] <= hist_d;
    end
  end

endmodule
`default_nettype wire

[hdl/kmsd_merge.sv]
// Merge stage: folds the lane results into the debounced key bitmap.
// Depends on kmsd_pkg for the lane result type.
`timescale 1ns / 1ps
`default_nettype none
module kmsd_merge #(
  parameter int unsigned ROWS = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          scan_i,
  input  kmsd_pkg::lane_res_t [ROWS-1:0]     res_i,
  output logic [kmsd_pkg::KeySlots-1:0]      bitmap_o,
  output logic [kmsd_pkg::KeySlots-1:0]      bitmap_next_o,
  output logic                               changed_o
);

  logic [kmsd_pkg::KeySlots-1:0] bitmap_q;
  logic [kmsd_pkg::KeySlots-1:0] bitmap_d;
  logic                          changed;

  always_comb begin
    bitmap_d = bitmap_q;
    changed  = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      if (res_i[r].rise) begin
        bitmap_d[res_i[r].key] = 1'b1;
        changed = 1'b1;
      end
      if (res_i[r].fall) begin
        bitmap_d[res_i[r].key] = 1'b0;
        changed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q <= '0;
    end else if (scan_i) begin
      bitmap_q <= bitmap_d;
    end
  end

  assign bitmap_o      = bitmap_q;
  assign bitmap_next_o = bitmap_d;
  assign changed_o     = changed;

endmodule
`default_nettype wire

[hdl/key_matrix_scan_debounce_core.sv]
// Top level of the key matrix scan and debounce core.
// Depends on kmsd_pkg, kmsd_lane and kmsd_merge.
//
// Accepts one sample per clock cycle while results are taken. Its result is
// registered and shows in the cycle after the input transfer. A result that waits
// holds off the input; a new sample is taken in the cycle in which the waiting
// result transfers. On a scan all ROWS lanes update the histories of used keys
// for the driven column in the same cycle and the merge stage folds their
// verdicts into the key bitmap. A scan happens on an input transfer when the
// wrapped tick difference since the last scan exceeds the interval register.
`timescale 1ns / 1ps
`default_nettype none
module key_matrix_scan_debounce_core #(
  parameter int unsigned ROWS         = 4,
  parameter int unsigned COLUMNS      = 4,
  parameter int unsigned HISTORY_BITS = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [kmsd_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [kmsd_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [kmsd_pkg::TickW-1:0]           now_ticks_i,
  input  wire logic [kmsd_pkg::RowInputBits-1:0]    row_levels_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      scanned_o,
  output logic                                      changed_o,
  output logic [kmsd_pkg::KeySlots-1:0]             key_state_o,
  output logic [kmsd_pkg::DriveW-1:0]               drive_column_o
);

  localparam int unsigned ColW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [kmsd_pkg::TickW-1:0]    interval_q;
  logic [kmsd_pkg::MaskW-1:0]    used_mask_q;
  logic [kmsd_pkg::TickW-1:0]    last_scan_q;
  logic [ColW-1:0]               col_q;
  logic [ColW-1:0]               col_d;
  logic                          out_valid_q;
  logic                          scanned_q;
  logic                          changed_q;
  logic [kmsd_pkg::KeySlots-1:0] key_state_q;
  logic [kmsd_pkg::DriveW-1:0]   drive_q;

  logic                          in_xfer;
  logic                          scan;
  logic [kmsd_pkg::TickW-1:0]    diff;
  logic [kmsd_pkg::KeySlots-1:0] bitmap;
  logic [kmsd_pkg::KeySlots-1:0] bitmap_next;
  logic                          changed;
  logic [ROWS-1:0]               sample;
  kmsd_pkg::lane_res_t [ROWS-1:0] res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign diff       = now_ticks_i - last_scan_q;
  assign scan       = in_xfer && (diff > interval_q);
  assign col_d      = (col_q == ColW'(COLUMNS - 1)) ? '0 : col_q + ColW'(1);

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    if (r < kmsd_pkg::RowInputBits) begin : g_pin
      assign sample[r] = ~row_levels_i[r];
    end else begin : g_nopin
      assign sample[r] = 1'b0;
    end
    kmsd_lane #(
      .ROWS         (ROWS),
      .COLUMNS      (COLUMNS),
      .HISTORY_BITS (HISTORY_BITS),
      .LANE         (r)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .scan_i      (scan),
      .col_i       (col_q),
      .sample_i    (sample[r]),
      .used_mask_i (used_mask_q),
      .bitmap_i    (bitmap),
      .res_o       (res[r])
    );
  end

  kmsd_merge #(
    .ROWS (ROWS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .scan_i        (scan),
    .res_i         (res),
    .bitmap_o      (bitmap),
    .bitmap_next_o (bitmap_next),
    .changed_o     (changed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= kmsd_pkg::ScanIntervalReset;
      used_mask_q <= kmsd_pkg::UsedKeyMaskReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kmsd_pkg::RegScanInterval: interval_q  <= cfg_wdata_i;
        kmsd_pkg::RegUsedKeyMask:  used_mask_q <= cfg_wdata_i[kmsd_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_scan_q <= '0;
      col_q       <= '0;
    end else if (scan) begin
      last_scan_q <= now_ticks_i;
      col_q       <= col_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      scanned_q   <= scan;
      changed_q   <= scan && changed;
      key_state_q <= scan ? bitmap_next : bitmap;
      drive_q     <= kmsd_pkg::DriveW'(scan ? col_d : col_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scanned_o      = scanned_q;
  assign changed_o      = changed_q;
  assign key_state_o    = key_state_q;
  assign drive_column_o = drive_q;

  // Skipped samples leave the scan state alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !scan) |=> ($stable(col_q) && $stable(bitmap) && $stable(last_scan_q)))
    else $error("state moved without a scan");

  // A change is only ever reported on a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !(changed_o && !scanned_o))
    else $error("change flagged without a scan");

  // A reported change must show in the bitmap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan && changed) |=> (bitmap != $past(bitmap)))
    else $error("change flagged but bitmap unchanged");

  // A scan always advances the column when there is more than one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan && (COLUMNS > 1)) |=> (col_q != $past(col_q)))
    else $error("column did not advance");

endmodule
`default_nettype wire
